### sv/msbp_pkg.sv
// Package for the MSB-first bit-field packer.
// Holds the field widths, codes, sequencer state type and result record.
// No dependencies.
`default_nettype none

package msbp_pkg;

	// Field widths of the request and result channels
	localparam int VALUE_W = 64;
	localparam int WIDTH_W = 7;
	localparam int BYTE_W  = 8;
	localparam int POS_W   = 8;
	localparam int FILL_W  = 3;

	// Record buffer capacity and longest field taken in one request
	localparam int BUFFER_BYTES   = 220;
	localparam int MAX_FIELD_BITS = 64;
	// Widths above this are cut down to whole bytes
	localparam int SHORT_FIELD_BITS = 16;

	// Request opcodes
	localparam logic OP_PACK   = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	// Result kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SHIFT,
		S_FLUSH,
		S_DONE
	} msbp_state_t;

	// One result record
	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] byte_value;
		logic [POS_W-1:0]  byte_index;
		logic [POS_W-1:0]  byte_count;
		logic              overflow;
		logic              last;
	} msbp_rsp_t;

endpackage

`default_nettype wire

### sv/msbp_if.sv
// Channel interfaces of the MSB-first bit-field packer: field requests in,
// packed bytes and record completions out. Depends on msbp_pkg.
`default_nettype none

interface msbp_in_if
	import msbp_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               op;
	logic [VALUE_W-1:0] field_value;
	logic [WIDTH_W-1:0] field_width;

	modport source(output valid, op, field_value, field_width, input ready);
	modport sink(input valid, op, field_value, field_width, output ready);
endinterface

interface msbp_out_if
	import msbp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [BYTE_W-1:0] byte_value;
	logic [POS_W-1:0]  byte_index;
	logic [POS_W-1:0]  byte_count;
	logic              overflow;
	logic              last;

	modport source(output valid, kind, byte_value, byte_index, byte_count, overflow, last,
		input ready);
	modport sink(input valid, kind, byte_value, byte_index, byte_count, overflow, last,
		output ready);
endinterface

`default_nettype wire

### sv/msb_first_bitfield_packer.sv
// MSB-first bit-field packer, top level.
//
// Channels: din carries requests (op, field_value, field_width); dout carries
// results (kind, byte_value, byte_index, byte_count, overflow, last). Both use
// valid/ready; a request moves on a clock edge with valid and ready high.
// A pack request shifts its effective-width bits (width up to 16, else whole
// bytes, at most 64) into the byte assembler one bit per clock while not stalled, MSB first,
// and emits each completed byte. A finish request emits the zero-padded
// partial byte, if any, then a completion carrying the byte count.
// Flow: din.ready is high only while the sequencer is idle, so a new
// request is not taken before the previous one is finished. A result is
// registered in the output register before it appears at dout.
// The last result of each request carries last = 1.
// Stall: results pass through a one-entry output register; when it is full
// and dout.ready is low, the bit step that would complete a byte waits.
// Reset (arst_n low, asynchronous) empties the output register and clears
// the partial byte, its fill count and the byte position.
// Depends on msbp_pkg, msbp_if and msbp_out_reg.
`default_nettype none

module msb_first_bitfield_packer
	import msbp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	msbp_in_if.sink   din,
	msbp_out_if.source dout
);

	msbp_state_t        state_q, state_d;
	logic [VALUE_W-1:0] value_q;
	logic [WIDTH_W-1:0] cnt_q;
	logic [BYTE_W-1:0]  partial_q;
	logic [FILL_W-1:0]  fill_q;
	logic [POS_W-1:0]   pos_q;

	logic               accept;
	logic [WIDTH_W-1:0] eff_width;
	logic [WIDTH_W-1:0] bit_sel;
	logic               cur_bit;
	logic [BYTE_W-1:0]  shifted;
	logic               byte_full;
	logic               step;
	logic               can_load;
	logic               load;
	msbp_rsp_t          rsp;
	logic [POS_W-1:0]   pos_inc;
	logic [BYTE_W-1:0]  padded;

	assign din.ready = (state_q == S_IDLE);
	assign accept    = din.valid && din.ready;

	// Effective width: short fields as given, longer ones in whole bytes, clamped
	always_comb begin
		if (din.field_width <= WIDTH_W'(SHORT_FIELD_BITS)) begin
			eff_width = din.field_width;
		end else begin
			eff_width = {din.field_width[WIDTH_W-1:3], 3'b000};
		end
		if (eff_width > WIDTH_W'(MAX_FIELD_BITS)) begin
			eff_width = WIDTH_W'(MAX_FIELD_BITS);
		end
	end

	// Bit select of the shared shift step: bit cnt-1 of the field
	assign bit_sel   = cnt_q - WIDTH_W'(1);
	assign cur_bit   = value_q[bit_sel[5:0]];
	assign shifted   = {partial_q[BYTE_W-2:0], cur_bit};
	assign byte_full = (fill_q == FILL_W'(BYTE_W - 1));

	// Saturating byte position
	assign pos_inc = (pos_q == {POS_W{1'b1}}) ? pos_q : pos_q + POS_W'(1);

	// Partial byte left-aligned and zero-padded
	assign padded = partial_q << (BYTE_W - int'(fill_q));

	// Sequencer: next state and result formation
	always_comb begin
		state_d = state_q;
		step    = 1'b0;
		load    = 1'b0;
		rsp     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (din.op == OP_FINISH) begin
						state_d = (fill_q != '0) ? S_FLUSH : S_DONE;
					end else if (eff_width != '0) begin
						state_d = S_SHIFT;
					end
				end
			end
			S_SHIFT: begin
				if (!byte_full || can_load) begin
					step = 1'b1;
					if (byte_full) begin
						load           = 1'b1;
						rsp.kind       = KIND_DATA;
						rsp.byte_value = shifted;
						rsp.byte_index = pos_q;
						rsp.overflow   = (pos_q >= POS_W'(BUFFER_BYTES));
						// fewer than a byte of bits left after this one
						rsp.last       = (cnt_q <= WIDTH_W'(BYTE_W));
					end
					if (cnt_q == WIDTH_W'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			S_FLUSH: begin
				if (can_load) begin
					load           = 1'b1;
					rsp.kind       = KIND_DATA;
					rsp.byte_value = padded;
					rsp.byte_index = pos_q;
					rsp.overflow   = (pos_q >= POS_W'(BUFFER_BYTES));
					state_d        = S_DONE;
				end
			end
			S_DONE: begin
				if (can_load) begin
					load           = 1'b1;
					rsp.kind       = KIND_DONE;
					rsp.byte_count = pos_q;
					rsp.overflow   = (pos_q > POS_W'(BUFFER_BYTES));
					rsp.last       = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and byte assembler
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			partial_q <= '0;
			fill_q    <= '0;
			pos_q     <= '0;
		end else begin
			state_q <= state_d;
			if (accept && din.op == OP_PACK) begin
				cnt_q <= eff_width;
			end else if (step) begin
				cnt_q <= cnt_q - WIDTH_W'(1);
			end
			if (step) begin
				if (byte_full) begin
					partial_q <= '0;
					fill_q    <= '0;
					pos_q     <= pos_inc;
				end else begin
					partial_q <= shifted;
					fill_q    <= fill_q + FILL_W'(1);
				end
			end else if (state_q == S_FLUSH && can_load) begin
				partial_q <= '0;
				fill_q    <= '0;
				pos_q     <= pos_inc;
			end else if (state_q == S_DONE && can_load) begin
				partial_q <= '0;
				fill_q    <= '0;
				pos_q     <= '0;
			end
		end
	end

	// Field bits, held for the shift steps
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= din.field_value;
		end
	end

	msbp_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.rsp      (rsp),
		.can_load (can_load),
		.dout     (dout)
	);

	// Shifting always has bits left
	a_shift_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (cnt_q != '0))
		else $error("shift state with no bits left");

	// Flush only with a partial byte present
	a_flush_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) |-> (fill_q != '0))
		else $error("flush with empty partial byte");

	// Completion restarts the record
	a_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && can_load) |=>
		(state_q == S_IDLE && pos_q == '0 && fill_q == '0))
		else $error("record not restarted after completion");

	// A byte leaves the assembler only when it is full
	a_byte_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && load) |-> byte_full)
		else $error("data byte emitted before it was full");

endmodule

`default_nettype wire

### sv/msbp_out_reg.sv
// Output register of the bit-field packer: holds one result until taken.
// Depends on msbp_pkg and msbp_out_if.
`default_nettype none

module msbp_out_reg
	import msbp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire msbp_rsp_t  rsp,
	output logic            can_load,
	msbp_out_if.source      dout
);

	logic      valid_q;
	msbp_rsp_t data_q;

	// Slot is free when empty or being drained this cycle
	assign can_load = !valid_q || dout.ready;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (dout.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= rsp;
		end
	end

	assign dout.valid      = valid_q;
	assign dout.kind       = data_q.kind;
	assign dout.byte_value = data_q.byte_value;
	assign dout.byte_index = data_q.byte_index;
	assign dout.byte_count = data_q.byte_count;
	assign dout.overflow   = data_q.overflow;
	assign dout.last       = data_q.last;

	// A load never overwrites a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!valid_q || dout.ready))
		else $error("result overwritten while stalled");

	// A stalled result keeps its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !dout.ready) |=> (valid_q && $stable(data_q)))
		else $error("stalled result changed");

	// Valid rises only through a load
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_q && !load) |=> !valid_q)
		else $error("valid without load");

endmodule

`default_nettype wire
